// File: sv/srag_pkg.sv
// shared types for the smallest range block
// command and status words between srag_ctrl and srag_dp
`default_nettype none
package srag_pkg;

  typedef struct packed {
    logic store;     // write the input word and bump the count
    logic start;     // set best range to all ones, first candidate
    logic rd_cand;   // read candidate minimum
    logic lat_cand;  // latch candidate, restart group walk
    logic rd_elem;   // read one group member
    logic eval;      // compare member against candidate
    logic grp_end;   // close group, move to next
    logic cand_end;  // fold candidate into best, next candidate
    logic finish;    // load result, clear count
  } cmd_t;

  typedef struct packed {
    logic too_few;
    logic k_end;
    logic g_last;
    logic i_last;
  } sts_t;

endpackage
`default_nettype wire

// File: sv/smallest_range_across_groups_top.sv
// smallest range across groups: loads one word per cycle while not stalled, then scans the data set.
// the scan reads the value memory through its single read port, walking every member
// of every group for each candidate.
// a short data set answers without a scan, with the flag set.
// synchronous reset clears the count, group count to 1; the memory is not cleared.
`default_nettype none
module smallest_range_across_groups_top #(
  parameter int MAX_ITEMS  = 1024,
  parameter int MAX_GROUPS = 64,
  parameter int VALUE_BITS = 30
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [6:0]            cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [VALUE_BITS-1:0] sample_value,
  input  wire logic                  item_last,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [VALUE_BITS-1:0]      min_range,
  output logic                       too_few_items
);
  import srag_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srag_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .item_last (item_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  srag_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .MAX_GROUPS (MAX_GROUPS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .sample_value  (sample_value),
    .cmd           (cmd),
    .sts           (sts),
    .min_range     (min_range),
    .too_few_items (too_few_items)
  );

endmodule
`default_nettype wire

// File: sv/srag_ctrl.sv
// controller state machine for the smallest range block
// depends on srag_pkg; drives srag_dp through cmd_t
`default_nettype none
module srag_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          item_last,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire srag_pkg::sts_t sts,
  output srag_pkg::cmd_t     cmd
);
  import srag_pkg::*;

  typedef enum logic [2:0] {
    LOAD, CHECK, CAND_RD, CAND_LAT, EL_RD, EL_EV, GRP_END, CAND_END
  } state_t;

  // FIN folded into an extra encoding would overflow 3 bits; use separate flag
  state_t state, state_next;
  logic   fin, fin_next;
  logic   accept;

  always_comb begin
    cmd        = '0;
    state_next = state;
    fin_next   = 1'b0;
    in_stall   = 1'b1;
    accept     = 1'b0;
    if (fin) begin
      cmd.finish = 1'b1;
      state_next = LOAD;
    end else begin
      case (state)
        LOAD: begin
          // hold a last word while the previous result is still waiting
          in_stall  = out_valid & item_last;
          accept    = in_valid & ~in_stall;
          cmd.store = accept;
          if (accept && item_last) state_next = CHECK;
        end
        CHECK: begin
          if (sts.too_few) begin
            fin_next = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = CAND_RD;
          end
        end
        CAND_RD: begin
          cmd.rd_cand = 1'b1;
          state_next  = CAND_LAT;
        end
        CAND_LAT: begin
          cmd.lat_cand = 1'b1;
          state_next   = EL_RD;
        end
        EL_RD: begin
          if (sts.k_end) begin
            state_next = GRP_END;
          end else begin
            cmd.rd_elem = 1'b1;
            state_next  = EL_EV;
          end
        end
        EL_EV: begin
          cmd.eval   = 1'b1;
          state_next = EL_RD;
        end
        GRP_END: begin
          cmd.grp_end = 1'b1;
          state_next  = sts.g_last ? CAND_END : EL_RD;
        end
        CAND_END: begin
          cmd.cand_end = 1'b1;
          if (sts.i_last) fin_next = 1'b1;
          else state_next = CAND_RD;
        end
        default: state_next = LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      fin       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fin   <= fin_next;
      if (fin) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: sv/srag_dp.sv
// datapath: value memory, group walk counters, range registers
// depends on srag_pkg; sequenced by srag_ctrl
`default_nettype none
module srag_dp #(
  parameter int MAX_ITEMS  = 1024,
  parameter int MAX_GROUPS = 64,
  parameter int VALUE_BITS = 30
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [6:0]            cfg_data,
  input  wire logic [VALUE_BITS-1:0] sample_value,
  input  wire srag_pkg::cmd_t        cmd,
  output srag_pkg::sts_t             sts,
  output logic [VALUE_BITS-1:0]      min_range,
  output logic                       too_few_items
);
  import srag_pkg::*;

  localparam int AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNTW = $clog2(MAX_ITEMS + 1);
  localparam int GW   = $clog2(MAX_GROUPS + 1);
  localparam int KW   = $clog2(MAX_ITEMS + MAX_GROUPS + 1);
  localparam int CW   = ((GW > 7) ? GW : 7) + 1;

  logic [VALUE_BITS-1:0] mem [MAX_ITEMS];
  logic [VALUE_BITS-1:0] rdata;
  logic [AW-1:0]         rd_addr;

  logic [6:0]            gcount;
  logic [CW-1:0]         gc_ext;
  logic [GW-1:0]         groups;
  logic [CNTW-1:0]       count;
  logic [CNTW-1:0]       i;
  logic [KW-1:0]         k;
  logic [GW-1:0]         g;
  logic [VALUE_BITS-1:0] cand;
  logic [VALUE_BITS-1:0] gbest;
  logic                  found;
  logic [VALUE_BITS-1:0] gmax;
  logic                  cand_ok;
  logic [VALUE_BITS-1:0] best;
  logic [VALUE_BITS-1:0] span;

  // group count zero reads as one, large counts clamp
  always_comb begin
    gc_ext = CW'(gcount);
    if (gc_ext == '0) groups = GW'(1);
    else if (gc_ext > CW'(MAX_GROUPS)) groups = GW'(MAX_GROUPS);
    else groups = GW'(gc_ext);
  end

  assign span        = gmax - cand;
  assign rd_addr     = cmd.rd_cand ? i[AW-1:0] : k[AW-1:0];
  assign sts.too_few = KW'(count) < KW'(groups);
  assign sts.k_end   = k >= KW'(count);
  assign sts.g_last  = KW'(g) + KW'(1) == KW'(groups);
  assign sts.i_last  = KW'(i) + KW'(1) == KW'(count);

  always_ff @(posedge clk) begin
    if (cmd.store && count < CNTW'(MAX_ITEMS)) mem[count[AW-1:0]] <= sample_value;
    if (cmd.rd_cand || cmd.rd_elem) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gcount <= 7'd1;
      count  <= '0;
    end else begin
      if (cfg_we) gcount <= cfg_data;
      if (cmd.finish) count <= '0;
      else if (cmd.store && count < CNTW'(MAX_ITEMS)) count <= count + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best <= '1;
      i    <= '0;
    end
    if (cmd.lat_cand) begin
      cand    <= rdata;
      k       <= '0;
      g       <= '0;
      found   <= 1'b0;
      gmax    <= '0;
      cand_ok <= 1'b1;
    end
    if (cmd.eval) begin
      // smallest member not below the candidate
      if (rdata >= cand && (!found || rdata < gbest)) begin
        gbest <= rdata;
        found <= 1'b1;
      end
      k <= k + KW'(groups);
    end
    if (cmd.grp_end) begin
      if (!found) cand_ok <= 1'b0;
      else if (gbest > gmax) gmax <= gbest;
      found <= 1'b0;
      g     <= g + GW'(1);
      k     <= KW'(g) + KW'(1);
    end
    if (cmd.cand_end) begin
      if (cand_ok && span < best) best <= span;
      i <= i + CNTW'(1);
    end
    if (cmd.finish) begin
      too_few_items <= sts.too_few;
      min_range     <= sts.too_few ? '0 : best;
    end
  end

endmodule
`default_nettype wire

// File: tb/testbench.sv
// testbench for smallest_range_across_groups_top: data sets are dealt round robin
// into groups, a scoreboard class predicts the smallest covering range per set.
// depends on the top level only; input gaps and receiver stall are random.
`default_nettype none
module testbench;

  localparam int VBITS     = 30;
  localparam int MAXITEMS  = 1024;
  localparam int MAXGROUPS = 64;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [VBITS-1:0] range;
    logic             short_set;
  } range_word_t;

  class range_scoreboard;
    logic [VBITS-1:0] loaded[$];
    logic [6:0]       group_reg = 7'd1;
    range_word_t      pending[$];
    int               errors = 0;

    function void set_groups(logic [6:0] v);
      group_reg = v;
    endfunction

    // smallest range over one value per group, heads walk down from the top
    function range_word_t best_cover();
      range_word_t      res;
      int               g;
      int               maxg;
      logic [VBITS-1:0] grp[MAXGROUPS][$];
      int               head[MAXGROUPS];
      logic [VBITS-1:0] maxv, minv, diff, best;
      g = (group_reg == 0) ? 1 : (group_reg > MAXGROUPS ? MAXGROUPS : group_reg);
      if (loaded.size() < g) begin
        res.range = '0;
        res.short_set = 1'b1;
        return res;
      end
      for (int k = 0; k < loaded.size(); k++) grp[k % g].insert(grp[k % g].size(), loaded[k]);
      for (int i = 0; i < g; i++) begin
        grp[i].sort();
        head[i] = grp[i].size() - 1;
      end
      best = '1;
      forever begin
        maxg = 0;
        maxv = grp[0][head[0]];
        minv = maxv;
        for (int i = 1; i < g; i++) begin
          if (grp[i][head[i]] > maxv) begin
            maxv = grp[i][head[i]];
            maxg = i;
          end
          if (grp[i][head[i]] < minv) minv = grp[i][head[i]];
        end
        diff = maxv - minv;
        if (diff < best) best = diff;
        if (head[maxg] == 0) break;
        head[maxg]--;
      end
      res.range = best;
      res.short_set = 1'b0;
      return res;
    endfunction

    function void note_word(logic [VBITS-1:0] v, logic last);
      if (loaded.size() < MAXITEMS) loaded.insert(loaded.size(), v);
      if (last) begin
        pending.insert(pending.size(), best_cover());
        loaded.delete();
      end
    endfunction

    function void check_result(logic [VBITS-1:0] r, logic f);
      range_word_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result range %0d flag %0d", $time, r, f);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r !== e.range) begin
        $display("%0t: min_range expected %0d actual %0d", $time, e.range, r);
        errors++;
      end
      if (f !== e.short_set) begin
        $display("%0t: too_few_items expected %0d actual %0d", $time, e.short_set, f);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [6:0]       cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [VBITS-1:0] sample_value = '0;
  logic             item_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [VBITS-1:0] min_range;
  logic             too_few_items;

  range_scoreboard sb = new();
  longint cycles = 0;
  int     burst_left = 0;
  int     words_sent = 0;

  smallest_range_across_groups_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .sample_value(sample_value),
    .item_last(item_last), .out_valid(out_valid), .out_stall(out_stall),
    .min_range(min_range), .too_few_items(too_few_items)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(min_range, too_few_items);
  end

  // receiver stall: random stretches that are either open or choppy
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(5, 200)) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  task automatic write_groups(input logic [6:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_groups(v);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // one word; valid stays high inside a burst, gaps between bursts
  task automatic send_word(input logic [VBITS-1:0] v, input logic last);
    in_valid <= 1'b1;
    sample_value <= v;
    item_last <= last;
    do @(posedge clk); while (in_stall);
    sb.note_word(v, last);
    words_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic finish_set();
    in_valid <= 1'b0;
    wait_drained();
  endtask

  function automatic logic [VBITS-1:0] rand_value(input int kind);
    case (kind)
      0: return VBITS'($urandom_range(0, 15));
      1: return {VBITS{1'b1}} - VBITS'($urandom_range(0, 15));
      default: return VBITS'($urandom());
    endcase
  endfunction

  task automatic send_set(input int len, input int kind);
    for (int i = 0; i < len; i++) send_word(rand_value(kind), i == len - 1);
    finish_set();
  endtask

  initial begin
    int len, kind, g;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset group count of one, single word
    send_word(30'h3fffffff, 1'b1);
    finish_set();
    write_groups(7'd2);
    send_word('0, 1'b0);
    send_word(30'h3fffffff, 1'b1);
    finish_set();
    // equal heads, tie on the maximum
    write_groups(7'd3);
    send_word(30'd7, 1'b0);
    send_word(30'd7, 1'b0);
    send_word(30'd7, 1'b0);
    send_word(30'd2, 1'b0);
    send_word(30'd9, 1'b0);
    send_word(30'd7, 1'b1);
    finish_set();
    // too few words for the groups
    write_groups(7'd4);
    send_word(30'h2aaaaaaa, 1'b0);
    send_word(30'h15555555, 1'b1);
    finish_set();
    // group count zero acts as one
    write_groups(7'd0);
    send_set(3, 2);
    // group count above the maximum is clamped
    write_groups(7'd127);
    send_set(64, 2);
    write_groups(7'd64);
    send_set(63, 2);
    send_set(70, 0);
    // overlong data set, words past the store size are dropped
    send_set(MAXITEMS + 6, 2);

    while (words_sent < 2000) begin
      case ($urandom_range(0, 3))
        0: g = $urandom_range(1, 4);
        1: g = $urandom_range(5, 16);
        2: g = $urandom_range(0, 127);
        default: g = $urandom_range(1, 64);
      endcase
      if ($urandom_range(0, 2) == 0) write_groups(g[6:0]);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 40);
      kind = $urandom_range(0, 3);
      send_set(len, kind);
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
